[hw/rtl/sha_pkg.sv]
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned LenOffset  = 56;

  // cfg register index
  localparam logic [0:0] RegDigest224 = 1'b0;

  localparam logic [31:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] Iv256 [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] Iv224 [8] = '{
    32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
    32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
  };

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,
    StRound = 6'b000100,
    StAdd   = 6'b001000,
    StLen   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  // round unit control from the sequencer
  typedef struct packed {
    logic       start;
    logic       step;
    logic [5:0] round;
  } rnd_ctrl_t;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[hw/rtl/sha_round.sv]
module sha_round
  import sha_pkg::*;
(
  input  logic           clk_i,
  input  rnd_ctrl_t      ctrl_i,
  input  logic [31:0]    chain_i [8],
  input  logic [31:0]    block_i [16],
  output logic [31:0]    vars_o  [8]
);

  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] w_new, w_t, t1, t2, a, e;
  logic [3:0]  idx;

  assign idx = ctrl_i.round[3:0];
  assign a   = v_q[0];
  assign e   = v_q[4];

  // message schedule word for this round
  always_comb begin
    w_new = (rotr(w_q[idx - 4'd2], 17) ^ rotr(w_q[idx - 4'd2], 19) ^ (w_q[idx - 4'd2] >> 10))
          + w_q[idx - 4'd7]
          + (rotr(w_q[idx - 4'd15], 7) ^ rotr(w_q[idx - 4'd15], 18) ^ (w_q[idx - 4'd15] >> 3))
          + w_q[idx];
    w_t = ctrl_i.round[5:4] == 2'd0 ? w_q[idx] : w_new;
    t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[ctrl_i.round] + w_t;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      v_q <= chain_i;
      w_q <= block_i;
    end else if (ctrl_i.step) begin
      w_q[idx] <= w_t;
      for (int i = 7; i > 0; i--) begin
        if (i != 4) v_q[i] <= v_q[i-1];
      end
      v_q[4] <= v_q[3] + t1;
      v_q[0] <= t1 + t2;
    end
  end

  assign vars_o = v_q;

endmodule

[hw/rtl/sha224_sha256_hash.sv]
// byte items: taken only while idle; the 64th byte of a block starts a compression (64 rounds
// of the shared round unit plus load and chain add) and no item is taken until it ends
// last item: padding fills bytes and loads the length, then one or two compressions, then
// one digest word per accepted output item
// rst_ni is asynchronous active low: sha-256 mode, empty message, idle
module sha224_sha256_hash
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  state_e      st_q;
  logic        mode_q, pad_q, two_q, fin_q;
  logic [31:0] chain_q [8];
  logic [31:0] blk_q   [16];
  logic [31:0] vars    [8];
  logic [6:0]  cnt_q;
  logic [5:0]  rnd_q;
  logic [63:0] bits_q;
  logic [2:0]  wi_q;
  rnd_ctrl_t   ctrl;
  logic        cfg_wr, in_acc, put;
  logic [7:0]  put_val;
  logic [5:0]  pos;
  logic        lenblk_q;

  assign pready = 1'b1;
  assign prdata = {31'd0, mode_q};
  assign cfg_wr = psel && penable && pwrite && (paddr == {RegDigest224, 1'b0});
  assign in_ready_o = (st_q == StIdle) && !cfg_wr;
  assign in_acc = in_valid_i && in_ready_o;

  assign ctrl.start = (st_q == StRound) && (rnd_q == 6'd0) && !fin_q;
  assign ctrl.step  = (st_q == StRound) && fin_q;
  assign ctrl.round = rnd_q;

  sha_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .chain_i(chain_q),
    .block_i(blk_q),
    .vars_o (vars)
  );

  // byte packing into the block
  assign pos = cnt_q[5:0];
  always_comb begin
    put = 1'b0;
    put_val = 8'h00;
    if (in_acc && has_byte_i) begin
      put = 1'b1;
      put_val = msg_byte_i;
    end else if (st_q == StPad) begin
      put = 1'b1;
      put_val = pad_q ? 8'h80 : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      unique case (pos[1:0])
        2'd0: blk_q[pos[5:2]] <= {put_val, 24'd0};
        2'd1: blk_q[pos[5:2]][23:16] <= put_val;
        2'd2: blk_q[pos[5:2]][15:8] <= put_val;
        default: blk_q[pos[5:2]][7:0] <= put_val;
      endcase
    end else if (st_q == StLen) begin
      blk_q[14] <= bits_q[63:32];
      blk_q[15] <= bits_q[31:0];
    end
  end

  // sequencer; fin_q splits load cycle from round cycles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; mode_q <= 1'b0; pad_q <= 1'b0; two_q <= 1'b0; fin_q <= 1'b0;
      cnt_q <= '0; rnd_q <= '0; bits_q <= '0; wi_q <= '0;
      chain_q <= Iv256;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (cfg_wr) begin
            mode_q <= pwdata[0];
            chain_q <= pwdata[0] ? Iv224 : Iv256;
            cnt_q <= '0; bits_q <= '0;
          end else if (in_acc) begin
            if (has_byte_i) bits_q <= bits_q + 64'd8;
            two_q <= 1'b0;
            if (has_byte_i && cnt_q == 7'd63) begin
              cnt_q <= '0;
              rnd_q <= '0; fin_q <= 1'b0;
              pad_q <= is_last_i;
              st_q <= StRound;
            end else begin
              if (has_byte_i) cnt_q <= cnt_q + 7'd1;
              if (is_last_i) begin
                pad_q <= 1'b1;
                st_q <= StPad;
              end
            end
          end
        end
        StPad: begin
          pad_q <= 1'b0;
          if (cnt_q == 7'd63) begin
            cnt_q <= '0; rnd_q <= '0; fin_q <= 1'b0; two_q <= 1'b1;
            st_q <= StRound;
          end else begin
            cnt_q <= cnt_q + 7'd1;
            if (cnt_q == 7'(LenOffset - 1) && !two_q) st_q <= StLen;
          end
        end
        StLen: begin
          cnt_q <= '0; rnd_q <= '0; fin_q <= 1'b0; two_q <= 1'b0;
          st_q <= StRound;
        end
        StRound: begin
          if (!fin_q) fin_q <= 1'b1;
          else begin
            rnd_q <= rnd_q + 6'd1;
            if (rnd_q == 6'(Rounds - 1)) st_q <= StAdd;
          end
        end
        default: ;
      endcase
      if (st_q == StAdd) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars[i];
        fin_q <= 1'b0; rnd_q <= '0;
        if (two_q) begin
          // second pass of a two-block pad
          pad_q <= 1'b0; cnt_q <= '0; two_q <= 1'b0; st_q <= StPad;
        end else if (pad_q) begin
          // full block ended the message: pad a fresh block
          cnt_q <= '0; st_q <= StPad;
        end else begin
          st_q <= lenblk_q ? StOut : StIdle;
        end
        wi_q <= '0;
      end else if (st_q == StOut && out_ready_i) begin
        wi_q <= wi_q + 3'd1;
        if (last_word_o) begin
          st_q <= StIdle;
          chain_q <= mode_q ? Iv224 : Iv256;
          cnt_q <= '0; bits_q <= '0;
        end
      end
    end
  end

  // marks that the compression in flight holds the length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lenblk_q <= 1'b0;
    else if (st_q == StLen) lenblk_q <= 1'b1;
    else if (st_q == StAdd) lenblk_q <= 1'b0;
  end

  assign out_valid_o   = (st_q == StOut);
  assign digest_word_o = chain_q[wi_q];
  assign word_index_o  = wi_q;
  assign last_word_o   = mode_q ? (wi_q == 3'd6) : (wi_q == 3'd7);

endmodule

[hw/rtl/sha_checker.sv]
module sha_checker
  import sha_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] word_index_o,
  input logic       last_word_o
);

  // no input taken while digest is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while output valid");

  // words advance by one
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
    else $error("word index skipped");

  // digest starts at word zero
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> word_index_o == 3'd0) else $error("bad first word");

  // last word only at six or seven
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_word_o |-> word_index_o == 3'd6 || word_index_o == 3'd7)
    else $error("bad last word");

endmodule

bind sha224_sha256_hash sha_checker u_sha_checker (.*);
